[rtl/fpc_pkg.sv]
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared types and constants for the flux pulse capture block.
// ----------------------------------------------------------------------------
package fpc_pkg;

  // Field widths of the result request
  localparam int WIDTH_W   = 8;
  localparam int PULSE_W   = 20;

  // Default capture counter width
  localparam int CAPTURE_COUNT_BITS_DEF = 20;

  // Saturation point of a measured interval
  localparam logic [WIDTH_W-1:0] WIDTH_MAX = 8'd255;

  // Index rising edges that end a capture
  localparam logic [1:0] STOP_RISES = 2'd2;

  // Reset value of the limit register
  localparam logic [PULSE_W-1:0] PULSE_LIMIT_RST = 20'hFFFFF;

  // One pin sample
  typedef struct packed {
    logic start_req;
    logic data_level;
    logic index_level;
  } sample_t;

endpackage

[rtl/fpc_if.sv]
// ----------------------------------------------------------------------------
// fpc_in_if / fpc_out_if
// Valid/ready channels for pin samples and captured pulse widths.
// ----------------------------------------------------------------------------
interface fpc_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic data_level;
  logic index_level;

  modport source (output valid, start_req, data_level, index_level, input ready);
  modport sink   (input valid, start_req, data_level, index_level, output ready);
endinterface

interface fpc_out_if;
  logic                         valid;
  logic                         ready;
  logic [fpc_pkg::WIDTH_W-1:0]  pulse_width;
  logic                         done_res;
  logic [fpc_pkg::PULSE_W-1:0]  pulses_captured;

  modport source (output valid, pulse_width, done_res, pulses_captured, input ready);
  modport sink   (input valid, pulse_width, done_res, pulses_captured, output ready);
endinterface

[rtl/fpc_in_stage.sv]
// ----------------------------------------------------------------------------
// fpc_in_stage
// Input register: holds one accepted pin sample until the core takes it.
// ----------------------------------------------------------------------------
module fpc_in_stage (
  input  logic             clk,
  input  logic             rst,
  fpc_in_if.sink           in_ch,
  input  logic             take,
  output logic             smp_valid,
  output fpc_pkg::sample_t smp
);

  logic valid_q;

  // Accept when empty or when the held sample leaves this cycle
  assign in_ch.ready = !valid_q || take;
  assign smp_valid   = valid_q;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      valid_q <= 1'b1;
    end else if (take) begin
      valid_q <= 1'b0;
    end
  end

  // Load payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      smp.start_req   <= in_ch.start_req;
      smp.data_level  <= in_ch.data_level;
      smp.index_level <= in_ch.index_level;
    end
  end

endmodule

[rtl/fpc_core.sv]
// ----------------------------------------------------------------------------
// fpc_core
// Capture sequencer: edge detection, interval counting and result register.
// ----------------------------------------------------------------------------
module fpc_core #(
  parameter int CAPTURE_COUNT_BITS = fpc_pkg::CAPTURE_COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [fpc_pkg::PULSE_W-1:0] cfg_wdata,
  input  logic                        smp_valid,
  input  fpc_pkg::sample_t            smp,
  output logic                        take,
  fpc_out_if.source                   out_ch
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT_INDEX,
    PH_WAIT_HIGH,
    PH_WAIT_LOW,
    PH_MEASURE
  } phase_t;

  phase_t                        phase, phase_next;
  logic                          last_index, last_index_next;
  logic                          prev_data;
  logic [1:0]                    index_rises, index_rises_next;
  logic [fpc_pkg::WIDTH_W-1:0]   interval_count, interval_count_next;
  logic [CAPTURE_COUNT_BITS-1:0] emitted_count, emitted_count_next;
  logic [fpc_pkg::PULSE_W-1:0]   pulse_limit;
  logic [CAPTURE_COUNT_BITS-1:0] limit_cmp;
  logic [CAPTURE_COUNT_BITS-1:0] emitted_inc;
  logic [1:0]                    rises_inc;
  logic                          index_rise;
  logic                          emit;
  logic                          stop;
  logic                          res_valid;

  // Advance when the result slot is free or being drained
  assign take         = smp_valid && (!res_valid || out_ch.ready);
  assign out_ch.valid = res_valid;

  assign limit_cmp   = CAPTURE_COUNT_BITS'(pulse_limit);
  assign emitted_inc = emitted_count + 1'b1;
  assign rises_inc   = index_rises + 2'd1;
  assign index_rise  = !last_index && smp.index_level;

  // Next-state logic for one sample
  always_comb begin
    phase_next          = phase;
    last_index_next     = last_index;
    index_rises_next    = index_rises;
    interval_count_next = interval_count;
    emitted_count_next  = emitted_count;
    emit                = 1'b0;
    stop                = 1'b0;
    if (smp.start_req) begin
      phase_next          = PH_WAIT_INDEX;
      last_index_next     = smp.index_level;
      index_rises_next    = 2'd0;
      interval_count_next = '0;
      emitted_count_next  = '0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
        end
        PH_WAIT_INDEX: begin
          if (last_index && !smp.index_level) begin
            last_index_next = 1'b0;
            phase_next      = PH_WAIT_HIGH;
          end else begin
            last_index_next = smp.index_level;
          end
        end
        PH_WAIT_HIGH: begin
          if (smp.data_level) begin
            phase_next = PH_WAIT_LOW;
          end
        end
        PH_WAIT_LOW: begin
          // First boundary: sample index, open the first interval
          if (!smp.data_level) begin
            if (index_rise) begin
              index_rises_next = rises_inc;
            end
            last_index_next     = smp.index_level;
            interval_count_next = fpc_pkg::WIDTH_W'(1);
            phase_next          = PH_MEASURE;
          end
        end
        PH_MEASURE: begin
          if (prev_data && !smp.data_level) begin
            if (index_rise) begin
              index_rises_next = rises_inc;
              if (rises_inc == fpc_pkg::STOP_RISES) begin
                stop = 1'b1;
              end
            end
            last_index_next    = smp.index_level;
            emitted_count_next = emitted_inc;
            if (emitted_inc == limit_cmp) begin
              stop = 1'b1;
            end
            emit                = 1'b1;
            interval_count_next = fpc_pkg::WIDTH_W'(1);
            if (stop) begin
              phase_next = PH_IDLE;
            end
          end else if (interval_count < fpc_pkg::WIDTH_MAX) begin
            interval_count_next = interval_count + 1'b1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Hold state, limit register and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      last_index     <= 1'b0;
      prev_data      <= 1'b0;
      index_rises    <= 2'd0;
      interval_count <= '0;
      emitted_count  <= '0;
      pulse_limit    <= fpc_pkg::PULSE_LIMIT_RST;
      res_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        pulse_limit <= cfg_wdata;
      end
      if (take && emit) begin
        res_valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        res_valid <= 1'b0;
      end
      if (take) begin
        phase          <= phase_next;
        last_index     <= last_index_next;
        prev_data      <= smp.data_level;
        index_rises    <= index_rises_next;
        interval_count <= interval_count_next;
        emitted_count  <= emitted_count_next;
      end
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_ch.pulse_width     <= interval_count;
      out_ch.done_res        <= stop;
      out_ch.pulses_captured <= fpc_pkg::PULSE_W'(emitted_inc);
    end
  end

endmodule

[rtl/flux_pulse_capture.sv]
// ----------------------------------------------------------------------------
// flux_pulse_capture
// Floppy flux interval capture from per-cycle read-data and index samples.
// ----------------------------------------------------------------------------
// Takes one pin sample per cycle and keeps that rate as long as the result
// side takes widths when offered. Each sample passes an input register, then
// edge detection and counting, which load the width of the interval that the
// sample closes into the result register. A start request arms
// a capture: wait for index to fall, then for data high then low; from there
// each data falling edge emits the width of the interval just closed (in
// samples, saturated at 255). The last width carries done_res, set when
// pulse_limit widths are out or index rises for the second time. A result
// stalled at the output holds one further sample in the input register before
// the input side stalls. Write pulse_limit only while no capture is running.
// ----------------------------------------------------------------------------
module flux_pulse_capture #(
  parameter int CAPTURE_COUNT_BITS = fpc_pkg::CAPTURE_COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [fpc_pkg::PULSE_W-1:0] cfg_wdata,
  fpc_in_if.sink                      in_ch,
  fpc_out_if.source                   out_ch
);

  logic             smp_valid;
  logic             take;
  fpc_pkg::sample_t smp;

  // Register incoming samples
  fpc_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .take      (take),
    .smp_valid (smp_valid),
    .smp       (smp)
  );

  // Run the capture sequence
  fpc_core #(
    .CAPTURE_COUNT_BITS (CAPTURE_COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .smp_valid (smp_valid),
    .smp       (smp),
    .take      (take),
    .out_ch    (out_ch)
  );

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for flux_pulse_capture: predicts each emitted width.
// ----------------------------------------------------------------------------
// Pin samples go in as valid/ready requests. Every accepted sample also steps
// a local capture predictor, and the widths it emits are queued. The output
// monitor pops the oldest queued width for each accepted result and compares
// field by field. A short directed table runs first under the reset limit.
// Random phases follow, one per limit setting, and each is written while the
// block is idle. Most random stimulus is well-formed captures: arm, index
// pulse, then data pulses of random widths with occasional index rises.
// Noise and rearm bursts make up the rest.
// ----------------------------------------------------------------------------
module tb;

  localparam int CAP_BITS      = fpc_pkg::CAPTURE_COUNT_BITS_DEF;
  localparam int RANDOM_ITEMS  = 1150;
  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_ROWS      = 28;

  typedef enum logic [2:0] {
    CAP_IDLE, CAP_WAIT_INDEX, CAP_WAIT_HIGH, CAP_WAIT_LOW, CAP_MEASURE
  } cap_phase_t;

  typedef struct packed {
    logic [fpc_pkg::WIDTH_W-1:0] width;
    logic                        done;
    logic [fpc_pkg::PULSE_W-1:0] count;
  } width_rec_t;

  typedef struct {
    bit                          s;
    bit                          d;
    bit                          i;
    int                          reps;
    bit                          chk;
    logic [fpc_pkg::WIDTH_W-1:0] w;
    bit                          done;
    logic [fpc_pkg::PULSE_W-1:0] cnt;
  } stim_row_t;

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [fpc_pkg::PULSE_W-1:0]  cfg_wdata;

  fpc_in_if  in_ch ();
  fpc_out_if out_ch ();

  flux_pulse_capture DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predictor state
  cap_phase_t                   cap_phase;
  bit                           cap_last_index;
  bit                           cap_prev_data;
  logic [1:0]                   cap_rises;
  logic [fpc_pkg::WIDTH_W-1:0]  cap_interval;
  logic [CAP_BITS-1:0]          cap_emitted;
  logic [fpc_pkg::PULSE_W-1:0]  cap_limit;

  width_rec_t widths_due [$];
  int         mismatches;
  int         busy_items;
  bit         calm;

  // Directed samples: s, d, i, repeat, typed check, width, done, count
  stim_row_t directed_rows [0:NUM_ROWS-1] = '{
    // idle samples are dropped
    '{1'b0, 1'b1, 1'b1, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    '{1'b0, 1'b0, 1'b0, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    // arm, index falls, data high then low opens the first interval
    '{1'b1, 1'b0, 1'b1, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    '{1'b0, 1'b0, 1'b0, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    '{1'b0, 1'b1, 1'b0, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    '{1'b0, 1'b0, 1'b0, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    // shortest width
    '{1'b0, 1'b1, 1'b0, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    '{1'b0, 1'b0, 1'b0, 1,   1'b1, 8'd2,   1'b0, 20'd1},
    // long high run saturates the width
    '{1'b0, 1'b1, 1'b0, 300, 1'b0, 8'd0,   1'b0, 20'd0},
    '{1'b0, 1'b0, 1'b0, 1,   1'b1, 8'd255, 1'b0, 20'd2},
    // first index rise at a boundary
    '{1'b0, 1'b1, 1'b1, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    '{1'b0, 1'b0, 1'b1, 1,   1'b1, 8'd2,   1'b0, 20'd3},
    '{1'b0, 1'b1, 1'b0, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    '{1'b0, 1'b0, 1'b0, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    // second index rise ends the capture
    '{1'b0, 1'b1, 1'b1, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    '{1'b0, 1'b0, 1'b1, 1,   1'b1, 8'd2,   1'b1, 20'd5},
    // back to idle: ignored
    '{1'b0, 1'b1, 1'b0, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    '{1'b0, 1'b0, 1'b0, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    // arm again, measure partway, then rearm while busy
    '{1'b1, 1'b1, 1'b1, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    '{1'b0, 1'b0, 1'b0, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    '{1'b0, 1'b1, 1'b0, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    '{1'b0, 1'b0, 1'b0, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    '{1'b0, 1'b1, 1'b0, 5,   1'b0, 8'd0,   1'b0, 20'd0},
    '{1'b1, 1'b0, 1'b0, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    '{1'b0, 1'b0, 1'b1, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    '{1'b0, 1'b0, 1'b0, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    '{1'b0, 1'b1, 1'b0, 1,   1'b0, 8'd0,   1'b0, 20'd0},
    '{1'b0, 1'b0, 1'b0, 1,   1'b0, 8'd0,   1'b0, 20'd0}
  };

  // Toggle the clock every half period
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Step the capture predictor by one sample; return 1 when a width comes out
  function automatic bit capture_step(input bit s, input bit d, input bit i,
                                      output width_rec_t rec);
    bit hit;
    bit stop;
    hit  = 1'b0;
    stop = 1'b0;
    rec  = '0;
    if (s) begin
      cap_phase      = CAP_WAIT_INDEX;
      cap_last_index = i;
      cap_rises      = '0;
      cap_interval   = '0;
      cap_emitted    = '0;
      cap_prev_data  = d;
      return 1'b0;
    end
    case (cap_phase)
      CAP_WAIT_INDEX: begin
        if (cap_last_index && !i) begin
          cap_last_index = 1'b0;
          cap_phase      = CAP_WAIT_HIGH;
        end else begin
          cap_last_index = i;
        end
      end
      CAP_WAIT_HIGH: begin
        if (d) cap_phase = CAP_WAIT_LOW;
      end
      CAP_WAIT_LOW: begin
        // first boundary: sample index, open the first interval
        if (!d) begin
          if (!cap_last_index && i) cap_rises = cap_rises + 2'd1;
          cap_last_index = i;
          cap_interval   = 8'd1;
          cap_phase      = CAP_MEASURE;
        end
      end
      CAP_MEASURE: begin
        if (cap_prev_data && !d) begin
          if (!cap_last_index && i) begin
            cap_rises = cap_rises + 2'd1;
            if (cap_rises == fpc_pkg::STOP_RISES) stop = 1'b1;
          end
          cap_last_index = i;
          cap_emitted    = cap_emitted + 1'b1;
          if (cap_emitted == cap_limit[CAP_BITS-1:0]) stop = 1'b1;
          rec.width = cap_interval;
          rec.done  = stop;
          rec.count = cap_emitted;
          hit = 1'b1;
          if (stop) cap_phase = CAP_IDLE;
          cap_interval = 8'd1;
        end else if (cap_interval < fpc_pkg::WIDTH_MAX) begin
          cap_interval = cap_interval + 8'd1;
        end
      end
      default: cap_phase = CAP_IDLE;
    endcase
    cap_prev_data = d;
    return hit;
  endfunction

  function automatic bit coin();
    return $urandom_range(1) != 0;
  endfunction

  // Offer one sample request, hold it until taken, then predict its width
  task automatic send_sample(input bit s, input bit d, input bit i,
                             input bit use_typed = 1'b0,
                             input width_rec_t typed_rec = '0);
    width_rec_t rec;
    bit         hit;
    if (!calm && $urandom_range(99) < 24) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.start_req   <= s;
    in_ch.data_level  <= d;
    in_ch.index_level <= i;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (s || cap_phase != CAP_IDLE) busy_items++;
    calm = (busy_items >= 900 && busy_items < 1250);
    hit = capture_step(s, d, i, rec);
    if (use_typed) widths_due.push_back(typed_rec);
    else if (hit) widths_due.push_back(rec);
  endtask

  // Drop valid and wait until every predicted width has come out
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (widths_due.size() != 0);
  endtask

  task automatic write_limit(input logic [fpc_pkg::PULSE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cap_limit = value;
  endtask

  // Steer whatever capture is open toward its end via index rises
  task automatic drive_to_idle();
    while (cap_phase != CAP_IDLE) begin
      case (cap_phase)
        CAP_WAIT_INDEX: send_sample(1'b0, 1'b0, !cap_last_index);
        CAP_WAIT_HIGH:  send_sample(1'b0, 1'b1, 1'b0);
        CAP_WAIT_LOW:   send_sample(1'b0, 1'b0, 1'b0);
        default: begin
          if (cap_prev_data) send_sample(1'b0, 1'b0, !cap_last_index);
          else               send_sample(1'b0, 1'b1, cap_last_index);
        end
      endcase
    end
  endtask

  // One well-formed capture with random pulse widths and index activity
  task automatic send_capture();
    int pulses;
    int lo_len;
    bit idx;
    pulses = $urandom_range(1, 40);
    idx    = 1'b0;
    send_sample(1'b1, coin(), coin());
    repeat ($urandom_range(1, 3)) send_sample(1'b0, coin(), 1'b1);
    send_sample(1'b0, coin(), 1'b0);
    for (int k = 0; k < pulses && cap_phase != CAP_IDLE; k++) begin
      if ($urandom_range(9) == 0) idx = !idx;
      lo_len = ($urandom_range(149) == 0) ? $urandom_range(245, 270)
                                          : $urandom_range(1, 6);
      repeat ($urandom_range(1, 4)) send_sample(1'b0, 1'b1, idx);
      repeat (lo_len) send_sample(1'b0, 1'b0, idx);
      if ($urandom_range(59) == 0) hold_until_drained();
    end
  endtask

  // Check each taken result against the oldest prediction; randomize ready
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (widths_due.size() == 0) begin
        $error("unexpected result: pulse_width %0d done_res %0d pulses_captured %0d",
               out_ch.pulse_width, out_ch.done_res, out_ch.pulses_captured);
        mismatches++;
      end else begin
        if (out_ch.pulse_width !== widths_due[0].width) begin
          $error("pulse_width: expected %0d, got %0d",
                 widths_due[0].width, out_ch.pulse_width);
          mismatches++;
        end
        if (out_ch.done_res !== widths_due[0].done) begin
          $error("done_res: expected %0d, got %0d",
                 widths_due[0].done, out_ch.done_res);
          mismatches++;
        end
        if (out_ch.pulses_captured !== widths_due[0].count) begin
          $error("pulses_captured: expected %0d, got %0d",
                 widths_due[0].count, out_ch.pulses_captured);
          mismatches++;
        end
        void'(widths_due.pop_front());
      end
    end
    out_ch.ready <= calm || ($urandom_range(99) >= 24);
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("FAIL flux_pulse_capture");
    $finish;
  end

  // Main sequence
  initial begin
    logic [fpc_pkg::PULSE_W-1:0] limit_plan [0:5];
    int                          base_items;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.start_req   <= 1'b0;
    in_ch.data_level  <= 1'b0;
    in_ch.index_level <= 1'b0;
    mismatches     = 0;
    busy_items     = 0;
    calm           = 1'b0;
    cap_phase      = CAP_IDLE;
    cap_last_index = 1'b0;
    cap_prev_data  = 1'b0;
    cap_rises      = '0;
    cap_interval   = '0;
    cap_emitted    = '0;
    cap_limit      = fpc_pkg::PULSE_LIMIT_RST;
    limit_plan[0] = 20'd1;
    limit_plan[1] = 20'd3;
    limit_plan[2] = 20'd0;
    limit_plan[3] = fpc_pkg::PULSE_W'($urandom_range(2, 40));
    limit_plan[4] = 20'hFFFFF;
    limit_plan[5] = fpc_pkg::PULSE_W'($urandom_range(1, 20'hFFFFF));
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table under the reset limit
    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        send_sample(directed_rows[r].s, directed_rows[r].d, directed_rows[r].i,
                    directed_rows[r].chk,
                    width_rec_t'{directed_rows[r].w, directed_rows[r].done,
                                 directed_rows[r].cnt});
      end
    end
    base_items = busy_items;

    // One random phase per limit setting, written only when idle
    foreach (limit_plan[p]) begin
      drive_to_idle();
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
      write_limit(limit_plan[p]);
      while (busy_items < base_items + (p + 1) * RANDOM_ITEMS / 6) begin
        if ($urandom_range(5) == 0) begin
          repeat ($urandom_range(1, 12))
            send_sample($urandom_range(7) == 0, coin(), coin());
        end else begin
          send_capture();
        end
      end
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && widths_due.size() == 0) begin
      $display("PASS flux_pulse_capture");
    end else begin
      $display("FAIL flux_pulse_capture");
    end
    $finish;
  end

endmodule
